FILE: rtl/core/ddwm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the differential drive wheel mixer.
package ddwm_pkg;

   localparam int SPEED_W    = 16;
   localparam int RAD_W      = 16;
   localparam int GAIN_W     = 16;
   localparam int TRACK_W    = 12;
   localparam int DUTY_W     = 8;
   localparam int MAXSPD_W   = 15;
   localparam int DECAY_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int NUM_W   = 31;              // |gain * speed|
   localparam int FAC_W   = 17;              // |2r -/+ track|
   localparam int PROD_W  = NUM_W + FAC_W;
   localparam int FRAC_W  = 16;              // Q0.16 scaling
   localparam int DIVD_W  = PROD_W - FRAC_W; // product after the Q0.16 shift
   localparam int DIVS_W  = 17;              // |2r|
   localparam int QUO_W   = 8;
   localparam int REM_W   = DIVS_W + QUO_W;
   localparam int CNT_W   = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_GAIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRACK_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_LIMIT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_FACTOR = 3'd4;

   localparam logic [GAIN_W-1:0]   RST_SPEED_GAIN   = 16'd6584;
   localparam logic [TRACK_W-1:0]  RST_TRACK_WIDTH  = 12'd485;
   localparam logic [DUTY_W-1:0]   RST_DUTY_LIMIT   = 8'd200;
   localparam logic [MAXSPD_W-1:0] RST_MAX_SPEED    = 15'd1200;
   localparam logic [DECAY_W-1:0]  RST_DECAY_FACTOR = 16'd58982;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_CLAMP,
      OP_MUL_DECAY,
      OP_WB_DECAY,
      OP_MUL_GAIN,
      OP_WB_DIRECT,
      OP_MUL_FACTOR,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_WB_DIV,
      OP_PUBLISH
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_MUL_DECAY,
      ST_WB_DECAY,
      ST_MUL_GAIN,
      ST_WB_DIRECT,
      ST_MUL_FACTOR,
      ST_DIV_INIT,
      ST_DIV_STEP,
      ST_WB_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic straight;
      logic spin;
      logic speed_zero;
      logic hold;
      logic div_sat;
      logic div_last;
      logic side_right;
   } status_type;

endpackage

FILE: rtl/core/ddwm_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the wheel mixer: handshakes and datapath operation order.
module ddwm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ddwm_pkg::cmd_type    cmd,
   input  ddwm_pkg::status_type status
);
   import ddwm_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NOP;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            cmd.op   = OP_CLAMP;
            state_in = (status.straight && status.speed_zero && !status.hold) ?
                       ST_MUL_DECAY : ST_MUL_GAIN;
         end
         ST_MUL_DECAY: begin
            cmd.op   = OP_MUL_DECAY;
            state_in = ST_WB_DECAY;
         end
         ST_WB_DECAY: begin
            cmd.op   = OP_WB_DECAY;
            state_in = ST_MUL_GAIN;
         end
         ST_MUL_GAIN: begin
            cmd.op   = OP_MUL_GAIN;
            state_in = (status.straight || status.spin) ? ST_WB_DIRECT : ST_MUL_FACTOR;
         end
         ST_WB_DIRECT: begin
            cmd.op   = OP_WB_DIRECT;
            state_in = ST_DONE;
         end
         ST_MUL_FACTOR: begin
            cmd.op   = OP_MUL_FACTOR;
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.op   = OP_DIV_INIT;
            state_in = ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            cmd.op = status.div_sat ? OP_NOP : OP_DIV_STEP;
            if (status.div_sat || status.div_last) begin
               state_in = ST_WB_DIV;
            end
         end
         ST_WB_DIV: begin
            cmd.op   = OP_WB_DIV;
            state_in = status.side_right ? ST_DONE : ST_MUL_FACTOR;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op       = OP_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/core/ddwm_datapath.sv
`timescale 1ns / 1ps
// Datapath of the wheel mixer: settings, clamps, shared multiplier, radix-2 divider.
module ddwm_datapath (
   input  logic                                     clock,
   input  logic                                     reset,
   input  ddwm_pkg::cmd_type                        cmd,
   output ddwm_pkg::status_type                     status,
   input  logic signed [ddwm_pkg::SPEED_W-1:0]      req_speed_cmd,
   input  logic signed [ddwm_pkg::RAD_W-1:0]        req_radius_cmd,
   input  logic                                     csr_we,
   input  logic [ddwm_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [ddwm_pkg::CSR_DATA_W-1:0]          csr_wdata,
   output logic [ddwm_pkg::DUTY_W-1:0]              rsp_left_duty,
   output logic [ddwm_pkg::DUTY_W-1:0]              rsp_right_duty,
   output logic                                     rsp_left_forward,
   output logic                                     rsp_right_forward
);
   import ddwm_pkg::*;

   function automatic logic [DUTY_W-1:0] sat_duty(input logic [FRAC_W-1:0] mag,
                                                  input logic [DUTY_W-1:0] lim);
      return (mag > FRAC_W'(lim)) ? lim : mag[DUTY_W-1:0];
   endfunction

   // settings
   logic [GAIN_W-1:0]   gain_ff;
   logic [TRACK_W-1:0]  track_ff;
   logic [DUTY_W-1:0]   limit_ff;
   logic [MAXSPD_W-1:0] maxspd_ff;
   logic [DECAY_W-1:0]  decay_ff;

   // persistent drive state
   logic signed [SPEED_W-1:0] last_ff;
   logic                      hold_ff;

   // working registers
   logic signed [SPEED_W-1:0] spd_ff;
   logic signed [RAD_W-1:0]   rad_ff;
   logic [NUM_W-1:0]          num_ff;
   logic [PROD_W-1:0]         prod_ff;
   logic                      neg_ff;
   logic                      side_ff;
   logic                      sat_ff;
   logic [REM_W-1:0]          rem_ff;
   logic [QUO_W-1:0]          quo_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic [DUTY_W-1:0]         dl_ff, dr_ff;
   logic                      fl_ff, fr_ff;
   logic [DUTY_W-1:0]         rsp_left_duty_ff, rsp_right_duty_ff;
   logic                      rsp_left_forward_ff, rsp_right_forward_ff;

   // input clamp to +/-max_speed
   logic signed [SPEED_W:0] sp_ext, max_ext, max_neg, sp_clamped;
   assign sp_ext     = (SPEED_W+1)'(req_speed_cmd);
   assign max_ext    = signed'({2'b00, maxspd_ff});
   assign max_neg    = -max_ext;
   assign sp_clamped = (sp_ext > max_ext) ? max_ext : ((sp_ext < max_neg) ? max_neg : sp_ext);

   // radius derived values
   logic signed [RAD_W+1:0] rad_ext, ar, ar_neg, spd_ext, spd_rad, twor, tw_mag, fac, fac_abs;
   logic                    straight, spin, spd_neg;
   logic [SPEED_W-1:0]      spd_mag, last_mag;
   logic [FAC_W-1:0]        fac_mag;
   logic [DIVS_W-1:0]       dvs;

   assign straight = (rad_ff == '0);
   assign spin     = (rad_ff == RAD_W'(1));
   assign spd_neg  = spd_ff[SPEED_W-1];
   assign rad_ext  = (RAD_W+2)'(rad_ff);
   assign ar       = rad_ff[RAD_W-1] ? -rad_ext : rad_ext;
   assign ar_neg   = -ar;
   assign spd_ext  = (RAD_W+2)'(spd_ff);
   assign spd_rad  = (spd_ext > ar) ? ar : ((spd_ext < ar_neg) ? ar_neg : spd_ext);
   assign twor     = rad_ext <<< 1;
   assign tw_mag   = rad_ff[RAD_W-1] ? -twor : twor;
   assign dvs      = tw_mag[DIVS_W-1:0];
   assign fac      = side_ff ? (twor + signed'((RAD_W+2)'(track_ff)))
                             : (twor - signed'((RAD_W+2)'(track_ff)));
   assign fac_abs  = fac[RAD_W+1] ? -fac : fac;
   assign fac_mag  = fac_abs[FAC_W-1:0];
   assign spd_mag  = spd_neg ? SPEED_W'(-spd_ff) : SPEED_W'(spd_ff);
   assign last_mag = last_ff[SPEED_W-1] ? SPEED_W'(-last_ff) : SPEED_W'(last_ff);

   // shared multiplier
   logic [NUM_W-1:0]  mul_a;
   logic [FAC_W-1:0]  mul_b;
   logic [PROD_W-1:0] mul_p;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MUL_DECAY: begin
            mul_a = NUM_W'(last_mag);
            mul_b = FAC_W'(decay_ff);
         end
         OP_MUL_GAIN: begin
            mul_a = NUM_W'(gain_ff);
            mul_b = FAC_W'(spd_mag);
         end
         OP_MUL_FACTOR: begin
            mul_a = num_ff;
            mul_b = fac_mag;
         end
         default: begin
         end
      endcase
   end

   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   // product after the Q0.16 shift
   logic [SPEED_W-2:0]      scaled;
   logic signed [SPEED_W-1:0] decayed;
   assign scaled  = prod_ff[FRAC_W+SPEED_W-2:FRAC_W];
   assign decayed = last_ff[SPEED_W-1] ? -signed'({1'b0, scaled}) : signed'({1'b0, scaled});

   // divider
   logic [DIVD_W-1:0] dividend, dvs_top;
   logic [REM_W-1:0]  trial;
   logic              fits;
   assign dividend = prod_ff[PROD_W-1:FRAC_W];
   assign dvs_top  = DIVD_W'(dvs) << QUO_W;
   assign trial    = REM_W'(dvs) << cnt_ff;
   assign fits     = (rem_ff >= trial);

   // duties
   logic                direct_nz, div_nz, div_fwd;
   logic [DUTY_W-1:0]   direct_duty, div_duty;
   logic [FRAC_W-1:0]   div_mag;
   assign direct_nz   = (scaled != '0);
   assign direct_duty = sat_duty(FRAC_W'(scaled), limit_ff);
   assign div_mag     = sat_ff ? (FRAC_W'(1) << QUO_W) : FRAC_W'(quo_ff);
   assign div_duty    = sat_duty(div_mag, limit_ff);
   assign div_nz      = sat_ff || (quo_ff != '0);
   assign div_fwd     = !(neg_ff && div_nz);

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= RST_SPEED_GAIN;
         track_ff  <= RST_TRACK_WIDTH;
         limit_ff  <= RST_DUTY_LIMIT;
         maxspd_ff <= RST_MAX_SPEED;
         decay_ff  <= RST_DECAY_FACTOR;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SPEED_GAIN:   gain_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_TRACK_WIDTH:  track_ff  <= csr_wdata[TRACK_W-1:0];
            CSR_DUTY_LIMIT:   limit_ff  <= csr_wdata[DUTY_W-1:0];
            CSR_MAX_SPEED:    maxspd_ff <= csr_wdata[MAXSPD_W-1:0];
            CSR_DECAY_FACTOR: decay_ff  <= csr_wdata[DECAY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
         hold_ff <= 1'b0;
      end else begin
         if (cmd.op == OP_WB_DECAY) begin
            last_ff <= decayed;
         end else if (cmd.op == OP_PUBLISH) begin
            if (straight) begin
               if (spd_ff != '0) begin
                  last_ff <= spd_ff;
                  hold_ff <= 1'b0;
               end
            end else if (spin) begin
               hold_ff <= 1'b1;
            end else begin
               hold_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            spd_ff  <= sp_clamped[SPEED_W-1:0];
            rad_ff  <= req_radius_cmd;
            side_ff <= 1'b0;
         end
         OP_CLAMP: begin
            if (!straight && !spin) begin
               spd_ff <= spd_rad[SPEED_W-1:0];
            end
         end
         OP_MUL_DECAY: begin
            prod_ff <= mul_p;
         end
         OP_WB_DECAY: begin
            spd_ff <= decayed;
         end
         OP_MUL_GAIN: begin
            prod_ff <= mul_p;
            num_ff  <= mul_p[NUM_W-1:0];
         end
         OP_WB_DIRECT: begin
            dl_ff <= direct_duty;
            dr_ff <= direct_duty;
            fl_ff <= !(spd_neg && direct_nz);
            fr_ff <= spin ? !(!spd_neg && direct_nz) : !(spd_neg && direct_nz);
         end
         OP_MUL_FACTOR: begin
            prod_ff <= mul_p;
            neg_ff  <= spd_neg ^ fac[RAD_W+1] ^ rad_ff[RAD_W-1];
         end
         OP_DIV_INIT: begin
            sat_ff <= (dividend >= dvs_top);
            rem_ff <= dividend[REM_W-1:0];
            quo_ff <= '0;
            cnt_ff <= CNT_W'(QUO_W - 1);
         end
         OP_DIV_STEP: begin
            rem_ff <= fits ? (rem_ff - trial) : rem_ff;
            quo_ff <= {quo_ff[QUO_W-2:0], fits};
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
         OP_WB_DIV: begin
            if (side_ff) begin
               dr_ff <= div_duty;
               fr_ff <= div_fwd;
            end else begin
               dl_ff <= div_duty;
               fl_ff <= div_fwd;
            end
            side_ff <= !side_ff;
         end
         OP_PUBLISH: begin
            rsp_left_duty_ff     <= dl_ff;
            rsp_right_duty_ff    <= dr_ff;
            rsp_left_forward_ff  <= fl_ff;
            rsp_right_forward_ff <= fr_ff;
         end
         default: begin
         end
      endcase
   end

   assign status.straight   = straight;
   assign status.spin       = spin;
   assign status.speed_zero = (spd_ff == '0);
   assign status.hold       = hold_ff;
   assign status.div_sat    = sat_ff;
   assign status.div_last   = (cnt_ff == '0);
   assign status.side_right = side_ff;

   assign rsp_left_duty     = rsp_left_duty_ff;
   assign rsp_right_duty    = rsp_right_duty_ff;
   assign rsp_left_forward  = rsp_left_forward_ff;
   assign rsp_right_forward = rsp_right_forward_ff;

endmodule

FILE: rtl/core/differential_drive_wheel_mixer.sv
`timescale 1ns / 1ps
// Top level of the differential drive wheel mixer.
//
//   port group   direction   flow control    beat contents
//   req_*        in          valid / stall   speed_cmd, radius_cmd
//   rsp_*        out         valid / stall   left/right duty, left/right forward
//   csr_*        in          valid / ready   register index, write data
//
// Straight and spin commands take the direct path, steering the divide path;
// zero speed straight, not held, decays first; a saturated wheel skips its divide.
// Steering runs each wheel through the shared 31x17 multiplier and an 8-step
// radix-2 divider, one wheel after the other.
// A new command is taken in the cycle after the previous result is registered,
// even while rsp is stalled; a finished result waits for a stalled rsp beat.
// Synchronous reset restores the register defaults and clears speed and hold.
module differential_drive_wheel_mixer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [ddwm_pkg::SPEED_W-1:0] req_speed_cmd,
   input  logic signed [ddwm_pkg::RAD_W-1:0]   req_radius_cmd,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ddwm_pkg::DUTY_W-1:0]         rsp_left_duty,
   output logic [ddwm_pkg::DUTY_W-1:0]         rsp_right_duty,
   output logic                                rsp_left_forward,
   output logic                                rsp_right_forward,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ddwm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ddwm_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ddwm_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   ddwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   ddwm_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_speed_cmd     (req_speed_cmd),
      .req_radius_cmd    (req_radius_cmd),
      .csr_we            (csr_valid & csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_left_duty     (rsp_left_duty),
      .rsp_right_duty    (rsp_right_duty),
      .rsp_left_forward  (rsp_left_forward),
      .rsp_right_forward (rsp_right_forward)
   );

endmodule

FILE: rtl/core/ddwm_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the wheel mixer and their binding to the top level.
module ddwm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic signed [ddwm_pkg::SPEED_W-1:0] req_speed_cmd,
   input logic signed [ddwm_pkg::RAD_W-1:0]   req_radius_cmd,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [ddwm_pkg::DUTY_W-1:0]         rsp_left_duty,
   input logic [ddwm_pkg::DUTY_W-1:0]         rsp_right_duty,
   input logic                                rsp_left_forward,
   input logic                                rsp_right_forward,
   input logic                                csr_valid,
   input logic                                csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_left_duty) &&
      $stable(rsp_right_duty) && $stable(rsp_left_forward) && $stable(rsp_right_forward))
      else $error("stalled rsp beat changed");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_speed_cmd) &&
      $stable(req_radius_cmd))
      else $error("stalled req beat changed");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("csr write not taken");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second req beat taken before result");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind differential_drive_wheel_mixer ddwm_checker u_ddwm_checker (.*);

FILE: tb/sv/differential_drive_wheel_mixer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the differential drive wheel mixer.
module differential_drive_wheel_mixer_tb;
   import ddwm_pkg::*;

   typedef struct packed {
      logic [DUTY_W-1:0] left_duty;
      logic [DUTY_W-1:0] right_duty;
      logic              left_forward;
      logic              right_forward;
   } wheel_beat_type;

   typedef enum {
      DRV_STRAIGHT,
      DRV_COAST,
      DRV_SPIN,
      DRV_STEER_ANY,
      DRV_STEER_NEAR,
      DRV_STEER_TIGHT,
      DRV_NOISE
   } drive_kind_type;

   localparam drive_kind_type DRIVE_MIX [10] = '{
      DRV_STRAIGHT, DRV_STRAIGHT, DRV_STRAIGHT, DRV_COAST, DRV_SPIN,
      DRV_STEER_ANY, DRV_STEER_NEAR, DRV_STEER_NEAR, DRV_STEER_TIGHT, DRV_NOISE
   };

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic signed [SPEED_W-1:0]  req_speed_cmd;
   logic signed [RAD_W-1:0]    req_radius_cmd;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [DUTY_W-1:0]          rsp_left_duty;
   logic [DUTY_W-1:0]          rsp_right_duty;
   logic                       rsp_left_forward;
   logic                       rsp_right_forward;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_DATA_W-1:0]      csr_wdata;

   // predictor copy of registers and state
   logic [GAIN_W-1:0]          cfg_gain;
   logic [TRACK_W-1:0]         cfg_track;
   logic [DUTY_W-1:0]          cfg_limit;
   logic [MAXSPD_W-1:0]        cfg_max_speed;
   logic [DECAY_W-1:0]         cfg_decay;
   logic signed [SPEED_W-1:0]  held_speed;
   logic                       hold_latched;

   wheel_beat_type             expected_duties [$];
   wheel_beat_type             want;
   int                         errors;
   logic                       req_idle_on;
   logic                       rsp_idle_on;

   differential_drive_wheel_mixer i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_speed_cmd     (req_speed_cmd),
      .req_radius_cmd    (req_radius_cmd),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_left_duty     (rsp_left_duty),
      .rsp_right_duty    (rsp_right_duty),
      .rsp_left_forward  (rsp_left_forward),
      .rsp_right_forward (rsp_right_forward),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic longint clamp_mag(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic logic [DUTY_W-1:0] duty_mag(longint pulse);
      longint m;
      m = (pulse < 0) ? -pulse : pulse;
      if (m > longint'(cfg_limit)) m = longint'(cfg_limit);
      return m[DUTY_W-1:0];
   endfunction

   function automatic wheel_beat_type mix_command(logic signed [SPEED_W-1:0] spd_in,
                                                  logic signed [RAD_W-1:0] rad_in);
      longint         spd;
      longint         rad;
      longint         twor;
      longint         num;
      longint         pl;
      longint         pr;
      wheel_beat_type beat;
      spd = clamp_mag(longint'(spd_in), longint'(cfg_max_speed));
      rad = longint'(rad_in);
      if (rad == 0) begin
         if (spd != 0) begin
            held_speed   = SPEED_W'(spd);
            hold_latched = 1'b0;
         end else if (!hold_latched) begin
            held_speed = SPEED_W'((longint'(held_speed) * longint'(cfg_decay)) / 65536);
            spd = longint'(held_speed);
         end
         pl = (longint'(cfg_gain) * spd) / 65536;
         pr = pl;
      end else if (rad == 1) begin
         pl = (longint'(cfg_gain) * spd) / 65536;
         pr = -pl;
         hold_latched = 1'b1;
      end else begin
         twor = 2 * rad;
         spd  = clamp_mag(spd, (rad < 0) ? -rad : rad);
         num  = longint'(cfg_gain) * spd;
         pl   = (num * (twor - longint'(cfg_track))) / (65536 * twor);
         pr   = (num * (twor + longint'(cfg_track))) / (65536 * twor);
         hold_latched = 1'b0;
      end
      beat.left_duty     = duty_mag(pl);
      beat.right_duty    = duty_mag(pr);
      beat.left_forward  = (pl >= 0);
      beat.right_forward = (pr >= 0);
      return beat;
   endfunction

   task automatic check_field(string name, logic [DUTY_W-1:0] exp_v, logic [DUTY_W-1:0] got_v);
      if (exp_v !== got_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_duties.size() == 0) begin
            errors++;
            $display("%0t: result beat with none expected, expected nothing, got %0d/%0d",
                     $time, rsp_left_duty, rsp_right_duty);
         end else begin
            want = expected_duties.pop_front();
            check_field("left_duty", want.left_duty, rsp_left_duty);
            check_field("right_duty", want.right_duty, rsp_right_duty);
            check_field("left_forward", DUTY_W'(want.left_forward), DUTY_W'(rsp_left_forward));
            check_field("right_forward", DUTY_W'(want.right_forward),
                        DUTY_W'(rsp_right_forward));
         end
      end
   end

   initial begin : rsp_backpressure
      int n;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         n = rsp_idle_on ? $urandom_range(0, 4) : 0;
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // leaves req_valid high after the beat is taken, for back-to-back beats
   task automatic send_command(logic signed [SPEED_W-1:0] spd, logic signed [RAD_W-1:0] rad);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_speed_cmd  <= spd;
      req_radius_cmd <= rad;
      do @(posedge clock); while (req_stall);
      expected_duties.push_back(mix_command(spd, rad));
   endtask

   task automatic drain_block;
      req_valid <= 1'b0;
      while (expected_duties.size() != 0) @(posedge clock);
      repeat (32) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SPEED_GAIN:   cfg_gain      = data[GAIN_W-1:0];
         CSR_TRACK_WIDTH:  cfg_track     = data[TRACK_W-1:0];
         CSR_DUTY_LIMIT:   cfg_limit     = data[DUTY_W-1:0];
         CSR_MAX_SPEED:    cfg_max_speed = data[MAXSPD_W-1:0];
         CSR_DECAY_FACTOR: cfg_decay     = data[DECAY_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_registers(logic [15:0] gain_v, logic [15:0] track_v,
                                 logic [15:0] limit_v, logic [15:0] maxs_v,
                                 logic [15:0] decay_v);
      write_reg(CSR_SPEED_GAIN, gain_v);
      write_reg(CSR_TRACK_WIDTH, track_v);
      write_reg(CSR_DUTY_LIMIT, limit_v);
      write_reg(CSR_MAX_SPEED, maxs_v);
      write_reg(CSR_DECAY_FACTOR, decay_v);
      csr_valid <= 1'b0;
   endtask

   function automatic int pick_level(int hi);
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return hi;
         default: return $urandom_range(0, hi);
      endcase
   endfunction

   task automatic random_command;
      logic signed [SPEED_W-1:0] spd;
      logic signed [RAD_W-1:0]   rad;
      drive_kind_type            kind;
      int                        m;
      int                        s;
      int                        k;
      kind = DRIVE_MIX[$urandom_range(0, 9)];
      m = int'(cfg_max_speed);
      if ($urandom_range(0, 3) == 0) begin
         spd = SPEED_W'($urandom);
      end else begin
         s = $urandom_range(0, 2 * m + 100) - (m + 50);
         if (s > 32767) s = 32767;
         if (s < -32768) s = -32768;
         spd = SPEED_W'(s);
      end
      case (kind)
         DRV_STRAIGHT: rad = 0;
         DRV_COAST: begin
            // a short coast run lets the decay compound
            k = $urandom_range(1, 3);
            repeat (k) send_command(0, 0);
            rad = 0;
         end
         DRV_SPIN:      rad = 1;
         DRV_STEER_ANY: rad = RAD_W'($urandom);
         DRV_STEER_NEAR: begin
            s = $urandom_range(2, int'(cfg_track) + 16);
            rad = RAD_W'($urandom_range(0, 1) ? -s : s);
         end
         DRV_STEER_TIGHT: begin
            s = $urandom_range(2, 40);
            rad = RAD_W'($urandom_range(0, 1) ? -s : s);
         end
         default: begin
            spd = SPEED_W'($urandom);
            rad = RAD_W'($urandom);
         end
      endcase
      send_command(spd, rad);
   endtask

   task automatic test_straight_drive;
      send_command(0, 0);
      send_command(1, 0);
      send_command(-1, 0);
      send_command(32767, 0);
      send_command(-32768, 0);
      send_command(600, 0);
   endtask

   task automatic test_coast_decay;
      send_command(1000, 0);
      send_command(0, 0);
      send_command(0, 0);
      send_command(-1200, 0);
      send_command(0, 0);
   endtask

   // spin latches hold, so a zero straight gives zero duty until a real speed clears it
   task automatic test_spin_hold;
      send_command(700, 1);
      send_command(0, 0);
      send_command(-32768, 1);
      send_command(0, 0);
      send_command(300, 0);
      send_command(0, 0);
   endtask

   task automatic test_steering;
      send_command(32767, 2);
      send_command(-32768, -2);
      send_command(1200, 242);
      send_command(1200, -243);
      send_command(-900, 485);
      send_command(0, 300);
      send_command(32767, 32767);
      send_command(-32768, -32768);
   endtask

   task automatic test_register_extremes;
      drain_block;
      load_registers(16'hFFFF, 16'd4095, 16'd255, 16'd32767, 16'hFFFF);
      send_command(32767, 0);
      send_command(0, 0);
      send_command(-32768, 32767);
      repeat (20) random_command();
      drain_block;
      load_registers(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_command(-32768, 0);
      send_command(32767, -5);
      repeat (8) random_command();
   endtask

   task automatic test_random_traffic;
      drain_block;
      load_registers(16'(RST_SPEED_GAIN), 16'(RST_TRACK_WIDTH), 16'(RST_DUTY_LIMIT),
                     16'(RST_MAX_SPEED), 16'(RST_DECAY_FACTOR));
      repeat (200) random_command();
      repeat (5) begin
         drain_block;
         load_registers(16'(pick_level(65535)), 16'(pick_level(4095)),
                        16'(pick_level(255)), 16'(pick_level(32767)),
                        16'(pick_level(65535)));
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         repeat (180) random_command();
      end
   endtask

   initial begin
      #(2_000_000);
      $display("differential_drive_wheel_mixer regression: fail");
      $finish;
   end

   initial begin
      errors         = 0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_speed_cmd  = '0;
      req_radius_cmd = '0;
      csr_valid      = 1'b0;
      csr_index      = CSR_SPEED_GAIN;
      csr_wdata      = '0;
      req_idle_on    = 1'b1;
      rsp_idle_on    = 1'b1;
      cfg_gain       = RST_SPEED_GAIN;
      cfg_track      = RST_TRACK_WIDTH;
      cfg_limit      = RST_DUTY_LIMIT;
      cfg_max_speed  = RST_MAX_SPEED;
      cfg_decay      = RST_DECAY_FACTOR;
      held_speed     = '0;
      hold_latched   = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_straight_drive();
      test_coast_decay();
      test_spin_hold();
      test_steering();
      test_register_extremes();
      test_random_traffic();
      drain_block();
      if (errors == 0)
         $display("differential_drive_wheel_mixer regression: pass");
      else
         $display("differential_drive_wheel_mixer regression: fail");
      $finish;
   end

endmodule
